// File: hw/rtl/qcf_pkg.sv
package qcf_pkg;

    localparam int TAPS   = 16;
    localparam int TIDX_W = $clog2(TAPS);
    localparam int DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_WRITE_TAP = 2'd1,
        CMD_CLR_HIST  = 2'd2,
        CMD_CLR_ALL   = 2'd3
    } cmd_t;

    // per-cycle controls broadcast to every cell
    typedef struct packed {
        logic shift;     // history moves one cell down the chain
        logic clr_hist;  // zero held sample
        logic clr_tap;   // zero held coefficient
        logic mul_en;    // register tap * sample
        logic sum_en;    // partial sum moves one cell down the chain
    } cell_ctl_t;

    // Cell k holds the sample k steps back, which is weighted by tap (TAPS - k) mod TAPS.
    function automatic logic [TIDX_W-1:0] tap_to_cell(input logic [3:0] t);
        int v;
        v = (TAPS - int'(t)) % TAPS;
        return TIDX_W'(v);
    endfunction

endpackage

// File: hw/rtl/qcf_cell.sv
module qcf_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  qcf_pkg::cell_ctl_t                  ctl,
    input  logic                                tap_we,
    input  logic signed [qcf_pkg::DATA_W-1:0]   tap_value,
    input  logic signed [qcf_pkg::DATA_W-1:0]   sample_in,
    output logic signed [qcf_pkg::DATA_W-1:0]   sample_out,
    input  logic        [qcf_pkg::DATA_W-1:0]   psum_in,
    output logic        [qcf_pkg::DATA_W-1:0]   psum_out
);

    logic signed [qcf_pkg::DATA_W-1:0]   sample_reg, sample_next;
    logic signed [qcf_pkg::DATA_W-1:0]   tap_reg, tap_next;
    logic        [qcf_pkg::DATA_W-1:0]   prod_reg, prod_next;
    logic        [qcf_pkg::DATA_W-1:0]   psum_reg, psum_next;
    logic signed [2*qcf_pkg::DATA_W-1:0] prod_full;

    always_comb
    begin
        sample_next = sample_reg;
        if (ctl.clr_hist)
        begin
            sample_next = '0;
        end
        else if (ctl.shift)
        begin
            sample_next = sample_in;
        end

        tap_next = tap_reg;
        if (ctl.clr_tap)
        begin
            tap_next = '0;
        end
        else if (tap_we)
        begin
            tap_next = tap_value;
        end
    end

    // floor(a*b / 2^15), low 16 bits
    assign prod_full = sample_reg * tap_reg;

    always_comb
    begin
        prod_next = ctl.mul_en ? prod_full[2*qcf_pkg::DATA_W-2:qcf_pkg::DATA_W-1] : prod_reg;
        psum_next = ctl.sum_en ? psum_in + prod_reg : psum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            tap_reg    <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            tap_reg    <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign sample_out = sample_reg;
    assign psum_out   = psum_reg;

endmodule

// File: hw/rtl/q15_circular_fir_filter.sv
// Q15 FIR filter, 16 taps, built as a chain of multiply/add cells.
// Sample beat: every cell registers its product and the partial sum ripples down the 16-cell
// chain; the result waits for a free output slot, and no beat is taken until it is on out_valid.
// Tap write and clear beats are taken back to back while idle and give no result.
// rst_n (async, active low) zeroes history, taps and control; no clearing pass is needed.
module q15_circular_fir_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [15:0] sample,
    input  logic [3:0]         tap_index,
    input  logic signed [15:0] tap_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] filtered
);

    // One-hot sequencer: IDLE takes commands, MUL registers products in every cell,
    // SUM ripples the partial sum down the chain one cell per cycle, DONE hands off.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [qcf_pkg::TIDX_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [qcf_pkg::DATA_W-1:0] filtered_reg, filtered_next;

    logic                       in_beat;
    qcf_pkg::cmd_t              cmd;
    qcf_pkg::cell_ctl_t         ctl;
    logic                       tap_ok;
    logic [qcf_pkg::TIDX_W-1:0] tap_cell;
    logic [qcf_pkg::TAPS-1:0]   tap_we;
    logic                       out_free;

    logic signed [qcf_pkg::DATA_W-1:0] sample_chain [qcf_pkg::TAPS+1];
    logic        [qcf_pkg::DATA_W-1:0] psum_chain   [qcf_pkg::TAPS+1];

    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign cmd      = qcf_pkg::cmd_t'(command);
    assign out_free = !out_valid_reg || out_ready;

    // taps beyond the table are dropped
    assign tap_ok   = (32'(tap_index) < 32'(qcf_pkg::TAPS));
    assign tap_cell = qcf_pkg::tap_to_cell(tap_index);

    always_comb
    begin
        ctl = '0;
        if (in_beat)
        begin
            case (cmd)
                qcf_pkg::CMD_SAMPLE:
                begin
                    ctl.shift = 1'b1;
                end
                qcf_pkg::CMD_CLR_HIST:
                begin
                    ctl.clr_hist = 1'b1;
                end
                qcf_pkg::CMD_CLR_ALL:
                begin
                    ctl.clr_hist = 1'b1;
                    ctl.clr_tap  = 1'b1;
                end
                default:
                begin
                    ctl = '0;
                end
            endcase
        end
        ctl.mul_en = (state_reg == ST_MUL);
        ctl.sum_en = (state_reg == ST_SUM);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && cmd == qcf_pkg::CMD_SAMPLE)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == qcf_pkg::TIDX_W'(qcf_pkg::TAPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // last cell's partial sum holds until the output slot frees up
                if (out_free)
                begin
                    filtered_next  = psum_chain[qcf_pkg::TAPS];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // chain heads: newest sample enters cell 0, partial sum starts at zero
    assign sample_chain[0] = sample;
    assign psum_chain[0]   = '0;

    for (genvar k = 0; k < qcf_pkg::TAPS; k++)
    begin : g_cell
        assign tap_we[k] = in_beat && (cmd == qcf_pkg::CMD_WRITE_TAP) && tap_ok
                           && (tap_cell == qcf_pkg::TIDX_W'(k));

        qcf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .tap_we     (tap_we[k]),
            .tap_value  (tap_value),
            .sample_in  (sample_chain[k]),
            .sample_out (sample_chain[k+1]),
            .psum_in    (psum_chain[k]),
            .psum_out   (psum_chain[k+1])
        );
    end

endmodule

// File: sim/q15_circular_fir_filter_tb.sv
`timescale 1ns / 1ps

module q15_circular_fir_filter_tb;

    // Scoreboard: keeps its own copy of history, taps and write position,
    // and queues the filter output expected for every accepted sample beat.
    class fir_scoreboard;
        logic signed [qcf_pkg::DATA_W-1:0] history [qcf_pkg::TAPS];
        logic signed [qcf_pkg::DATA_W-1:0] taps    [qcf_pkg::TAPS];
        logic [qcf_pkg::TIDX_W-1:0]        wr_pos;
        logic signed [qcf_pkg::DATA_W-1:0] expected_filtered [$];
        int                                errors;

        function new();
            errors = 0;
            clear_all();
        endfunction

        function void clear_history();
            foreach (history[i]) history[i] = '0;
        endfunction

        function void clear_all();
            clear_history();
            foreach (taps[i]) taps[i] = '0;
            wr_pos = '0;
        endfunction

        // store sample, sum Q15 products (floor), wrap to 16 bits, advance
        function logic signed [qcf_pkg::DATA_W-1:0] filter_sample(
            logic signed [qcf_pkg::DATA_W-1:0] smp);
            logic [qcf_pkg::DATA_W-1:0] acc;
            logic [qcf_pkg::TIDX_W-1:0] idx;
            int                         prod;
            acc = '0;
            history[wr_pos] = smp;
            for (int i = 0; i < qcf_pkg::TAPS; i++)
            begin
                idx  = wr_pos + qcf_pkg::TIDX_W'(i);
                prod = int'(history[idx]) * int'(taps[i]);
                prod = prod >>> 15;
                acc  = acc + prod[qcf_pkg::DATA_W-1:0];
            end
            wr_pos = wr_pos + 1'b1;
            return acc;
        endfunction

        function void note_beat(qcf_pkg::cmd_t cmd, logic signed [qcf_pkg::DATA_W-1:0] smp,
                                logic [3:0] tidx, logic signed [qcf_pkg::DATA_W-1:0] tval);
            case (cmd)
                qcf_pkg::CMD_SAMPLE:    expected_filtered.push_back(filter_sample(smp));
                qcf_pkg::CMD_WRITE_TAP: if (int'(tidx) < qcf_pkg::TAPS) taps[tidx] = tval;
                qcf_pkg::CMD_CLR_HIST:  clear_history();
                qcf_pkg::CMD_CLR_ALL:   clear_all();
                default:                ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_filtered(logic signed [qcf_pkg::DATA_W-1:0] got);
            logic signed [qcf_pkg::DATA_W-1:0] want;
            if (expected_filtered.size() == 0)
            begin
                report($sformatf("unexpected result filtered=%0d", got));
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (got !== want)
                    report($sformatf("filtered got %0d want %0d", got, want));
            end
        endtask

        function int pending();
            return expected_filtered.size();
        endfunction
    endclass

    // DUT signals; the inputs are known from time zero
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         command   = qcf_pkg::CMD_SAMPLE;
    logic signed [15:0] sample    = '0;
    logic [3:0]         tap_index = '0;
    logic signed [15:0] tap_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] filtered;

    fir_scoreboard sb;

    // idle control shared between the two sides
    bit in_calm   = 1'b0;   // sender runs without gaps while set
    bit out_calm  = 1'b0;   // receiver runs without stalls while set
    bit hold_req  = 1'b0;   // asks the receiver for one long hold-off
    bit reset_done = 1'b0;

    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 900;
    localparam int DRAIN_CYCLES  = 40;

    q15_circular_fir_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .sample    (sample),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random idle gap, none during a calm stretch
    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // random Q15 value, with the extremes and the values around zero
    // showing up often enough to matter
    function automatic logic signed [15:0] draw_q15();
        case ($urandom_range(0, 11))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive one input beat and hold it until in_ready; the gap after it
    // only drops in_valid when there really is an idle cycle, so in_valid
    // never sees two NBAs in one step.
    task automatic send_beat(qcf_pkg::cmd_t cmd, logic signed [15:0] smp,
                             logic [3:0] tidx, logic signed [15:0] tval);
        int gap;
        in_valid  <= 1'b1;
        command   <= cmd;
        sample    <= smp;
        tap_index <= tidx;
        tap_value <= tval;
        do @(posedge clk); while (!in_ready);
        sb.note_beat(cmd, smp, tidx, tval);
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // unused fields carry random junk; the block must ignore them
    task automatic send_sample(logic signed [15:0] smp);
        send_beat(qcf_pkg::CMD_SAMPLE, smp, 4'($urandom), 16'($urandom));
    endtask

    task automatic send_tap(logic [3:0] tidx, logic signed [15:0] tval);
        send_beat(qcf_pkg::CMD_WRITE_TAP, 16'($urandom), tidx, tval);
    endtask

    task automatic send_clear(qcf_pkg::cmd_t cmd);
        send_beat(cmd, 16'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic wait_results_done();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Receiver: random stall before each beat, plus one long hold-off on
    // request so the block backs up and stalls its input.
    initial
    begin
        int gap;
        wait (reset_done);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = draw_gap(out_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_filtered(filtered);
            if ($urandom_range(0, 49) == 0) out_calm = ($urandom_range(0, 2) == 0);
        end
    end

    // Stimulus
    initial
    begin
        int r;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reset_done = 1'b1;

        // Directed part
        send_sample(16'sh7FFF);                 // all taps zero after reset
        send_tap(4'd0, 16'sh8000);              // -1.0 on the newest sample
        send_tap(4'd15, 16'sh7FFF);             // highest slot, largest tap
        send_sample(16'sh8000);                 // -1.0 * -1.0 -> +1.0, wraps
        send_sample(16'sh7FFF);
        send_sample(16'shFFFF);                 // -1 lsb * -1.0 tap gives +1 lsb
        send_tap(4'd7, 16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh7FFF);
        send_clear(qcf_pkg::CMD_CLR_HIST);      // taps and position must survive
        send_sample(16'sh1234);
        send_tap(4'd3, 16'sh4000);
        send_tap(4'd8, 16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_clear(qcf_pkg::CMD_CLR_ALL);       // taps, history and position gone
        send_sample(16'sh7FFF);
        send_tap(4'd0, 16'sh7FFF);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh8000);

        // Random part: mostly samples over a tap set that keeps changing,
        // with occasional clears
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k % 60 == 0) in_calm = ($urandom_range(0, 3) == 0);
            if (k == 300) hold_req = 1'b1;          // receiver backs off, input fills
            if (k == 600)
            begin
                // sender pauses until drained; the last beat must not be offered again
                in_valid <= 1'b0;
                @(posedge clk);
                wait_results_done();
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                send_sample(draw_q15());
            else if (r < 90)
                send_tap(4'($urandom), draw_q15());
            else if (r < 95)
                send_clear(qcf_pkg::CMD_CLR_HIST);
            else
                send_clear(qcf_pkg::CMD_CLR_ALL);
        end

        in_valid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never came", sb.pending()));

        if (sb.errors == 0)
            $display("PASS q15_circular_fir_filter");
        else
            $display("FAIL q15_circular_fir_filter");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("FAIL q15_circular_fir_filter");
        $finish;
    end

endmodule
